### rtl/ece_pkg.sv
// Shared types and constants of the easing curve evaluator.
// Fixed-point formats, curve codes and the sine polynomial coefficients.
// No dependencies.
package ece_pkg;

  // Working precision: signed Q.30 values in a 34-bit datapath
  localparam int D_W = 34;
  localparam int QB = 30;
  localparam logic signed [D_W-1:0] QONE = D_W'(1) <<< QB;

  // Output format and bus width
  localparam int OUT_W = 25;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int KIND_W = 4;

  // Default widths of the input fields
  localparam int PFB_DEF = 16;
  localparam int DB_DEF = 24;

  // Square root datapath
  localparam int SQ_W = 62;
  localparam int SQ_STEPS = 31;

  // Back-out overshoot constants s and s+1 in Q.30
  localparam logic signed [D_W-1:0] BACK_S = 34'sd1827057613;
  localparam logic signed [D_W-1:0] BACK_S1 = 34'sd2900799437;

  // Taylor coefficients of sin(pi x / 2), highest order first
  localparam logic signed [D_W-1:0] SINE_COEF [7] = '{
    34'sd61, -34'sd3864, 34'sd172272, -34'sd5026995,
    34'sd85569306, -34'sd693598668, 34'sd1686629713
  };

  // Curve codes
  localparam logic [KIND_W-1:0] K_LINEAR     = 4'd0;
  localparam logic [KIND_W-1:0] K_SINE_INOUT = 4'd1;
  localparam logic [KIND_W-1:0] K_HALF_SINE  = 4'd2;
  localparam logic [KIND_W-1:0] K_BACK_OUT   = 4'd3;
  localparam logic [KIND_W-1:0] K_CIRC_IN    = 4'd4;
  localparam logic [KIND_W-1:0] K_CIRC_OUT   = 4'd5;
  localparam logic [KIND_W-1:0] K_CUBIC_IN   = 4'd6;
  localparam logic [KIND_W-1:0] K_CUBIC_OUT  = 4'd7;
  localparam logic [KIND_W-1:0] K_QUINT_IN   = 4'd8;
  localparam logic [KIND_W-1:0] K_QUINT_OUT  = 4'd9;

  // Data carried along the chain with each item
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [D_W-1:0]   distance;
    logic signed [D_W-1:0]   t;
    logic signed [D_W-1:0]   a;
    logic signed [D_W-1:0]   b;
  } side_t;

endpackage

### rtl/easing_curve_evaluator_core.sv
// Easing curve evaluator: a chain of multiply cells and square-root cells.
// Depends on ece_pkg, ece_mul_cell and ece_sqrt_cell.
//
// Usage:
//   Slave stream: tuser carries the curve kind, tdata carries distance
//   (signed, low bits) and progress (unsigned Q1.16 above it). Master stream:
//   tdata carries the signed Q25.0 offset = distance * curve(progress).
//   Progress above 1.0 is treated as 1.0; unknown kinds give zero.
//   The datapath is a 42-stage chain: an input register, nine multiply
//   cells (squaring, Horner steps of the sine polynomial, powers), 31
//   square-root cells (one result bit each) and a final scaling multiply.
//   One transaction is taken every cycle while the output is consumed.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and s_axis_tready goes low until the result is taken.
//   Reset clears all valid bits; no item is in flight afterwards.
module easing_curve_evaluator_core #(
  parameter int PROGRESS_FRAC_BITS = ece_pkg::PFB_DEF,
  parameter int DISTANCE_BITS = ece_pkg::DB_DEF,
  localparam int IN_TDATA_W = ((DISTANCE_BITS + PROGRESS_FRAC_BITS + 1 + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [distance, progress] from bit 0 up
  input  logic [IN_TDATA_W-1:0]              s_axis_tdata,
  // [kind]
  input  logic [ece_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [offset] from bit 0 up
  output logic [ece_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import ece_pkg::*;

  localparam int NMUL = 9;
  localparam int NSTG = 1 + NMUL + SQ_STEPS + 1;
  localparam int PW = PROGRESS_FRAC_BITS + 1;
  localparam logic [PW-1:0] P_ONE = PW'(1) << PROGRESS_FRAC_BITS;

  function automatic logic signed [D_W-1:0] clamp_one(input logic signed [D_W-1:0] x);
    logic signed [D_W-1:0] y;
    y = x;
    if (x < 0) y = '0;
    if (x > QONE) y = QONE;
    return y;
  endfunction

  logic adv;
  logic [NSTG-1:0] vld_q;
  logic signed [DISTANCE_BITS-1:0] dist_in;
  logic [PW-1:0] prog_in, prog_c;
  side_t in_d, in_q;
  side_t ms [NMUL+1];
  side_t sq_side [SQ_STEPS+1];
  logic [SQ_W-1:0] sq_n [SQ_STEPS+1];
  logic [SQ_W-1:0] sq_r [SQ_STEPS+1];
  logic signed [D_W-1:0] root_v;
  logic signed [D_W-1:0] ease;
  logic signed [D_W-1:0] root_res;
  side_t fin_side;

  // Advance the chain unless a result waits at the output
  assign adv = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // Unpack, saturate progress and convert it to Q.30
  always_comb begin
    dist_in = s_axis_tdata[DISTANCE_BITS-1:0];
    prog_in = s_axis_tdata[DISTANCE_BITS +: PW];
    prog_c = (prog_in > P_ONE) ? P_ONE : prog_in;
    in_d.kind = s_axis_tuser;
    in_d.distance = D_W'(dist_in);
    in_d.t = D_W'(prog_c) <<< (QB - PROGRESS_FRAC_BITS);
    in_d.a = '0;
    in_d.b = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_d;
    end
  end

  assign ms[0] = in_q;

  // Multiply cells: each stage picks its operands from the curve kind
  for (genvar g = 1; g <= NMUL; g++) begin : g_mul
    localparam int CI = (g >= 3 && g <= 7) ? g - 1 : 0;
    side_t sp, nx;
    logic signed [D_W-1:0] ma, mb, cc, u, s;

    assign sp = ms[g-1];

    always_comb begin
      nx = sp;
      ma = sp.a;
      mb = QONE;
      cc = '0;
      u = sp.t - QONE;
      s = clamp_one(sp.a);
      if (g == 1) begin
        case (sp.kind)
          K_LINEAR: ma = sp.t;
          K_BACK_OUT: begin
            ma = BACK_S1;
            mb = u;
            cc = BACK_S;
          end
          K_CIRC_OUT, K_CUBIC_OUT, K_QUINT_OUT: begin
            ma = u;
            mb = u;
          end
          K_SINE_INOUT, K_HALF_SINE, K_CIRC_IN, K_CUBIC_IN, K_QUINT_IN: begin
            ma = sp.t;
            mb = sp.t;
          end
          default: ma = '0;
        endcase
      end else if (g == 2) begin
        case (sp.kind)
          K_SINE_INOUT, K_HALF_SINE: begin
            nx.b = sp.a;
            ma = SINE_COEF[0];
            mb = sp.a;
            cc = SINE_COEF[1];
          end
          K_BACK_OUT: begin
            nx.b = sp.a;
            ma = u;
            mb = u;
          end
          K_CUBIC_IN: mb = sp.t;
          K_CUBIC_OUT: begin
            mb = u;
            cc = QONE;
          end
          K_QUINT_IN, K_QUINT_OUT: mb = sp.a;
          default: mb = QONE;
        endcase
      end else if (g == 3) begin
        case (sp.kind)
          K_SINE_INOUT, K_HALF_SINE: begin
            mb = sp.b;
            cc = SINE_COEF[3'(CI)];
          end
          K_BACK_OUT: begin
            mb = sp.b;
            cc = QONE;
          end
          K_QUINT_IN: mb = sp.t;
          K_QUINT_OUT: begin
            mb = u;
            cc = QONE;
          end
          default: mb = QONE;
        endcase
      end else if (g <= 7) begin
        if (sp.kind == K_SINE_INOUT || sp.kind == K_HALF_SINE) begin
          mb = sp.b;
          cc = SINE_COEF[3'(CI)];
        end
      end else if (g == 8) begin
        if (sp.kind == K_SINE_INOUT || sp.kind == K_HALF_SINE) begin
          mb = sp.t;
        end
      end else begin
        // Clamp the quarter sine, square it for the in-out curve
        if (sp.kind == K_SINE_INOUT) begin
          ma = s;
          mb = s;
        end else if (sp.kind == K_HALF_SINE) begin
          ma = s;
        end
      end
    end

    ece_mul_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .side_i (nx),
      .ma_i   (ma),
      .mb_i   (mb),
      .c_i    (cc),
      .side_o (ms[g])
    );
  end

  // Radicand of the circular curves: one minus the square, clamped to [0, 1]
  always_comb begin
    root_v = '0;
    if (ms[NMUL].kind == K_CIRC_IN || ms[NMUL].kind == K_CIRC_OUT) begin
      root_v = clamp_one(QONE - ms[NMUL].a);
    end
  end

  assign sq_side[0] = ms[NMUL];
  assign sq_n[0] = SQ_W'(root_v) << QB;
  assign sq_r[0] = '0;

  // Square root cells, one result bit per cell
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    ece_sqrt_cell #(
      .STEP (j)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .side_i (sq_side[j]),
      .n_i    (sq_n[j]),
      .r_i    (sq_r[j]),
      .side_o (sq_side[j+1]),
      .n_o    (sq_n[j+1]),
      .r_o    (sq_r[j+1])
    );
  end

  // Pick the eased value for the final scaling
  always_comb begin
    root_res = D_W'(sq_r[SQ_STEPS]);
    case (sq_side[SQ_STEPS].kind)
      K_CIRC_IN: ease = QONE - root_res;
      K_CIRC_OUT: ease = root_res;
      default: ease = sq_side[SQ_STEPS].a;
    endcase
  end

  ece_mul_cell u_scale (
    .clk_i  (clk_i),
    .en_i   (adv),
    .side_i (sq_side[SQ_STEPS]),
    .ma_i   (sq_side[SQ_STEPS].distance),
    .mb_i   (ease),
    .c_i    ('0),
    .side_o (fin_side)
  );

  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, fin_side.a[OUT_W-1:0]};

  // Ready follows the output stall exactly
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // Unknown curve kinds give a zero offset
  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && fin_side.kind > K_QUINT_OUT) |-> (m_axis_tdata == '0))
    else $error("unknown kind produced nonzero offset");

  // The root of a valid item never exceeds one
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTG-2] |-> (sq_r[SQ_STEPS] <= SQ_W'(QONE)))
    else $error("square root above one");

endmodule

### rtl/ece_mul_cell.sv
// Multiply cell of the evaluator chain: a = round(ma * mb / 2^30) + c.
// Registers the item's side data with the new product. Uses ece_pkg.
module ece_mul_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  ece_pkg::side_t                side_i,
  input  logic signed [ece_pkg::D_W-1:0] ma_i,
  input  logic signed [ece_pkg::D_W-1:0] mb_i,
  input  logic signed [ece_pkg::D_W-1:0] c_i,
  output ece_pkg::side_t                side_o
);
  import ece_pkg::*;

  localparam logic signed [2*D_W-1:0] HALF = (2*D_W)'(1) <<< (QB - 1);

  logic signed [2*D_W-1:0] prod;
  logic signed [2*D_W-1:0] rnd;
  side_t side_d, side_q;

  // Round to nearest, ties up, then add the offset term
  always_comb begin
    prod = ma_i * mb_i;
    rnd = prod + HALF;
    side_d = side_i;
    side_d.a = D_W'(rnd >>> QB) + c_i;
  end

  // Hold while the chain is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
    end
  end

  assign side_o = side_q;

endmodule

### rtl/ece_sqrt_cell.sv
// One bit-pair step of the restoring integer square root.
// A row of these cells forms the root of the circular curves. Uses ece_pkg.
module ece_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  ece_pkg::side_t               side_i,
  input  logic [ece_pkg::SQ_W-1:0]     n_i,
  input  logic [ece_pkg::SQ_W-1:0]     r_i,
  output ece_pkg::side_t               side_o,
  output logic [ece_pkg::SQ_W-1:0]     n_o,
  output logic [ece_pkg::SQ_W-1:0]     r_o
);
  import ece_pkg::*;

  localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (SQ_STEPS - 1 - STEP));

  logic [SQ_W-1:0] trial;
  logic [SQ_W-1:0] n_d, n_q, r_d, r_q;
  side_t side_q;

  // Subtract the trial value where it fits and set the result bit
  always_comb begin
    trial = r_i + BITV;
    if (n_i >= trial) begin
      n_d = n_i - trial;
      r_d = (r_i >> 1) + BITV;
    end else begin
      n_d = n_i;
      r_d = r_i >> 1;
    end
  end

  // Hold while the chain is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_d;
      r_q <= r_d;
      side_q <= side_i;
    end
  end

  assign side_o = side_q;
  assign n_o = n_q;
  assign r_o = r_q;

endmodule

### tb/tb_easing_curve_evaluator_core.sv
// Testbench for easing_curve_evaluator_core: streams curve requests with bursty
// input and a stalling receiver, and checks every offset against a Q.30 predictor.
// Depends on ece_pkg and the RTL of the easing curve evaluator.
`timescale 1ns / 1ps

class offset_scoreboard;
  logic [24:0] pending_q[$];
  int unsigned n_err;
  int unsigned n_checked;

  function void note_request(logic [24:0] offset);
    pending_q.push_back(offset);
  endfunction

  function void check_offset(logic [24:0] got);
    logic [24:0] want;
    if (pending_q.size() == 0) begin
      n_err++;
      if (n_err <= 10) $display("unexpected offset %h", got);
      return;
    end
    want = pending_q.pop_front();
    n_checked++;
    if (want !== got) begin
      n_err++;
      if (n_err <= 10) $display("offset mismatch: expected %h actual %h", want, got);
    end
  endfunction
endclass

module tb_easing_curve_evaluator_core;
  import ece_pkg::*;

  localparam int PFB = 16;
  localparam int DB = 24;
  localparam int IN_W = ((DB + PFB + 1 + 7) / 8) * 8;
  localparam longint LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // [distance, progress] from bit 0 up
  logic [IN_W-1:0] s_axis_tdata = '0;
  // [kind]
  logic [KIND_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [offset] from bit 0 up
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  offset_scoreboard sb = new();
  longint cycles = 0;
  int unsigned n_sent = 0;
  int unsigned kind_hits[16];
  logic stall_pattern_on = 1'b1;

  easing_curve_evaluator_core #(.PROGRESS_FRAC_BITS(PFB), .DISTANCE_BITS(DB)) DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // Round x / 2^30 to nearest, ties toward plus infinity
  function automatic longint q30_round(longint x);
    return (x + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return q30_round(a * b);
  endfunction

  function automatic longint sine_half_pi(longint x);
    longint z, acc;
    z = q30_mul(x, x);
    acc = SINE_COEF[0];
    for (int i = 1; i < 7; i++) acc = longint'(SINE_COEF[i]) + q30_mul(acc, z);
    acc = q30_mul(acc, x);
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
    return acc;
  endfunction

  // Floor square root of a Q.30 value, bit by bit
  function automatic longint root_q30(longint v);
    logic [63:0] n, res, b;
    if (v <= 0) return 0;
    if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
    n = 64'(v) << 30;
    res = 0;
    b = 64'd1 << 60;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [24:0] eased_offset(logic [3:0] kind, logic [DB-1:0] dist_raw,
                                               logic [PFB:0] prog_raw);
    longint one, dist_v, t, u, e, t2, u2, s;
    one = 64'sd1 <<< 30;
    dist_v = longint'($signed(dist_raw));
    t = (prog_raw > (1 << PFB)) ? one : (longint'(prog_raw) <<< (30 - PFB));
    u = t - one;
    case (kind)
      K_LINEAR:     e = t;
      K_SINE_INOUT: begin s = sine_half_pi(t); e = q30_mul(s, s); end
      K_HALF_SINE:  e = sine_half_pi(t);
      K_BACK_OUT:   e = q30_mul(q30_mul(u, u), q30_mul(BACK_S1, u) + BACK_S) + one;
      K_CIRC_IN:    e = one - root_q30(one - q30_mul(t, t));
      K_CIRC_OUT:   e = root_q30(one - q30_mul(u, u));
      K_CUBIC_IN:   e = q30_mul(q30_mul(t, t), t);
      K_CUBIC_OUT:  e = q30_mul(q30_mul(u, u), u) + one;
      K_QUINT_IN:   begin t2 = q30_mul(t, t); e = q30_mul(q30_mul(t2, t2), t); end
      K_QUINT_OUT:  begin u2 = q30_mul(u, u); e = q30_mul(q30_mul(u2, u2), u) + one; end
      default:      e = 0;
    endcase
    return 25'(q30_round(dist_v * e));
  endfunction

  // Hold one transaction until it is accepted
  task automatic send_request(logic [3:0] kind, logic [DB-1:0] distance, logic [PFB:0] prog);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= IN_W'({prog, distance});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(eased_offset(kind, distance, prog));
    kind_hits[kind]++;
    n_sent++;
  endtask

  task automatic idle_gap(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [PFB:0] random_progress();
    case ($urandom_range(0, 7))
      0: return 17'($urandom_range(65537, 131071));
      1: return 17'($urandom_range(0, 4));
      2: return 17'($urandom_range(65530, 65536));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [DB-1:0] random_distance();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      default: return 24'($urandom);
    endcase
  endfunction

  // Receiver: a stall pattern of its own, turned off for stretches
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_offset(m_axis_tdata[24:0]);
    m_axis_tready <= stall_pattern_on ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  // Timeout watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [DB-1:0] dists[4];
    logic [PFB:0] progs[4];
    int burst;
    dists = '{24'h000000, 24'h7fffff, 24'h800000, 24'h001000};
    progs = '{17'd0, 17'd65536, 17'd131071, 17'd32768};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every curve at the progress and distance extremes, plus unused kinds
    for (int k = 0; k < 10; k++) send_request(4'(k), dists[k % 4], progs[(k / 4 + k) % 4]);
    for (int k = 0; k < 10; k++) send_request(4'(k), dists[(k + 1) % 4], progs[(k + 2) % 4]);
    send_request(4'd10, 24'h7fffff, 17'd40000);
    send_request(4'd15, 24'h800000, 17'd65536);
    send_request(K_BACK_OUT, 24'h800000, 17'd20000);
    send_request(K_BACK_OUT, 24'h7fffff, 17'd20000);
    drain_results();

    // Random bursts; one stretch runs with no stall at all
    while (n_sent < 525) begin
      stall_pattern_on <= (n_sent < 300 || n_sent > 400);
      burst = $urandom_range(1, 30);
      repeat (burst)
        send_request(($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                  : 4'($urandom_range(0, 9)),
                     random_distance(), random_progress());
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 12));
      if (n_sent > 250 && n_sent < 290) drain_results();
    end

    drain_results();
    repeat (60) @(posedge clk_i);
    $display("Covered %0d requests over all ten curves and unused kinds, %0d offsets checked",
             n_sent, sb.n_checked);
    $display("with bursty input, receiver stalls and progress beyond one.");
    if (sb.n_err == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("mismatches %0d, left over %0d", sb.n_err, sb.pending_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### sim.f
rtl/ece_pkg.sv
rtl/ece_mul_cell.sv
rtl/ece_sqrt_cell.sv
rtl/easing_curve_evaluator_core.sv
tb/tb_easing_curve_evaluator_core.sv
